FILE: hdl/epsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epsp_pkg;

  localparam int CFG_W = 11;
  localparam int XY_W = 15;
  localparam int TS_W = 32;
  localparam int PIX_W = 16;
  localparam int HDR_BYTES = 28;
  localparam int PIX_OFFSET = 36;
  localparam int POL_LAST = 7;
  localparam int FRM_TS_LAST = 11;

  localparam logic [15:0] TYPE_POL = 16'd1;
  localparam logic [15:0] TYPE_FRM = 16'd2;

  typedef enum logic [1:0] {
    KIND_POL = 2'd0,
    KIND_PIX = 2'd1,
    KIND_TS  = 2'd2
  } epsp_kind_e;

  // One event byte handed from the front to the back.
  typedef struct packed {
    logic       frame;  // frame packet, else polarity packet
    logic       pix;    // at or past the pixel offset
    logic [3:0] pos;    // low bits of the byte offset in the event
    logic [7:0] data;
  } epsp_cmd_t;

  typedef struct packed {
    epsp_kind_e        kind;
    logic [XY_W-1:0]   x_addr;
    logic [XY_W-1:0]   y_addr;
    logic              polarity;
    logic [TS_W-1:0]   timestamp;
    logic [TS_W-1:0]   end_timestamp;
    logic [PIX_W-1:0]  pixel_value;
  } epsp_res_t;

  // Insert a byte into a little-endian word; byte zero clears the rest.
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = word;
    unique case (pos)
      2'd0: r = {24'd0, b};
      2'd1: r[15:8] = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
      default: r = word;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/epsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module epsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNTW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/epsp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module epsp_front
  import epsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  output logic            cmd_push_o,
  output epsp_cmd_t       cmd_o
);

  logic        in_header_q, in_header_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] pkt_type_q, pkt_type_d;
  logic [31:0] evt_size_q, evt_size_d;
  logic [31:0] evt_cap_q, evt_cap_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [31:0] evt_idx_q, evt_idx_d;
  logic [32:0] pos_inc, idx_inc;
  logic        is_pol, is_frm, small_pos, pix_pos;

  assign is_pol    = (pkt_type_q == TYPE_POL);
  assign is_frm    = (pkt_type_q == TYPE_FRM);
  assign small_pos = (byte_pos_q < 32'(FRM_TS_LAST + 1));
  assign pix_pos   = (byte_pos_q >= 32'(PIX_OFFSET));
  assign pos_inc   = {1'b0, byte_pos_q} + 33'd1;
  assign idx_inc   = {1'b0, evt_idx_q} + 33'd1;

  always_comb begin
    cmd_o.frame = is_frm;
    cmd_o.pix   = pix_pos;
    cmd_o.pos   = byte_pos_q[3:0];
    cmd_o.data  = data_byte_i;
    cmd_push_o  = accept_i && !in_header_q &&
                  ((is_pol && (byte_pos_q < 32'(POL_LAST + 1))) ||
                   (is_frm && (small_pos || pix_pos)));
  end

  always_comb begin
    in_header_d = in_header_q;
    hdr_cnt_d   = hdr_cnt_q;
    pkt_type_d  = pkt_type_q;
    evt_size_d  = evt_size_q;
    evt_cap_d   = evt_cap_q;
    byte_pos_d  = byte_pos_q;
    evt_idx_d   = evt_idx_q;
    if (accept_i) begin
      if (in_header_q) begin
        if (hdr_cnt_q < 5'd2) begin
          pkt_type_d = 16'(put_byte({16'd0, pkt_type_q}, hdr_cnt_q[1:0], data_byte_i));
        end else if (hdr_cnt_q >= 5'd4 && hdr_cnt_q < 5'd8) begin
          evt_size_d = put_byte(evt_size_q, hdr_cnt_q[1:0], data_byte_i);
        end else if (hdr_cnt_q >= 5'd16 && hdr_cnt_q < 5'd20) begin
          evt_cap_d = put_byte(evt_cap_q, hdr_cnt_q[1:0], data_byte_i);
        end
        if (hdr_cnt_q == 5'(HDR_BYTES - 1)) begin
          hdr_cnt_d   = '0;
          byte_pos_d  = '0;
          evt_idx_d   = '0;
          in_header_d = (evt_size_q == '0) || (evt_cap_q == '0);
        end else begin
          hdr_cnt_d = hdr_cnt_q + 5'd1;
        end
      end else begin
        if (pos_inc >= {1'b0, evt_size_q}) begin
          byte_pos_d = '0;
          if (idx_inc >= {1'b0, evt_cap_q}) begin
            evt_idx_d   = '0;
            in_header_d = 1'b1;
            hdr_cnt_d   = '0;
          end else begin
            evt_idx_d = idx_inc[31:0];
          end
        end else begin
          byte_pos_d = pos_inc[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q <= 1'b1;
      hdr_cnt_q   <= '0;
      pkt_type_q  <= '0;
      evt_size_q  <= '0;
      evt_cap_q   <= '0;
      byte_pos_q  <= '0;
      evt_idx_q   <= '0;
    end else begin
      in_header_q <= in_header_d;
      hdr_cnt_q   <= hdr_cnt_d;
      pkt_type_q  <= pkt_type_d;
      evt_size_q  <= evt_size_d;
      evt_cap_q   <= evt_cap_d;
      byte_pos_q  <= byte_pos_d;
      evt_idx_q   <= evt_idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/epsp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module epsp_back
  import epsp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire epsp_cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic             res_full_i,
  output logic                  res_valid_o,
  output epsp_res_t             res_o,
  input  wire logic [CFG_W-1:0] frame_width_i,
  input  wire logic [CFG_W-1:0] frame_height_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [31:0]    word_q, word_d;
  logic [31:0]    start_q, start_d;
  logic [7:0]     pix_lo_q, pix_lo_d;
  logic [CW-1:0]  column_q, column_d;
  logic [HW-1:0]  row_q, row_d;
  logic [WW-1:0]  width_eff;
  logic [HW-1:0]  height_eff;
  logic           advance;

  assign advance   = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = advance;

  // Zero reads as one, anything above the maximum as the maximum.
  always_comb begin
    if (frame_width_i == '0) begin
      width_eff = WW'(1);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      height_eff = HW'(1);
    end else if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height_i);
    end
  end

  always_comb begin
    word_d      = word_q;
    start_d     = start_q;
    pix_lo_d    = pix_lo_q;
    column_d    = column_q;
    row_d       = row_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_POL;
    if (advance) begin
      if (!cmd_i.frame) begin
        if (cmd_i.pos < 4'd4) begin
          word_d = put_byte(word_q, cmd_i.pos[1:0], cmd_i.data);
        end else begin
          start_d = put_byte(start_q, cmd_i.pos[1:0], cmd_i.data);
        end
        if (cmd_i.pos == 4'(POL_LAST)) begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_POL;
          res_o.x_addr   = word_q[31:17];
          res_o.y_addr   = word_q[16:2];
          res_o.polarity = word_q[1];
          res_o.timestamp = start_d;
        end
      end else if (!cmd_i.pix) begin
        if (cmd_i.pos == 4'd0) begin
          column_d = '0;
          row_d    = '0;
        end
        if (cmd_i.pos >= 4'd4 && cmd_i.pos < 4'd8) begin
          start_d = put_byte(start_q, cmd_i.pos[1:0], cmd_i.data);
        end else if (cmd_i.pos >= 4'd8) begin
          word_d = put_byte(word_q, cmd_i.pos[1:0], cmd_i.data);
        end
        if (cmd_i.pos == 4'(FRM_TS_LAST)) begin
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_TS;
          res_o.timestamp     = start_q;
          res_o.end_timestamp = word_d;
        end
      end else if (!cmd_i.pos[0]) begin
        pix_lo_d = cmd_i.data;
      end else if (row_q < height_eff) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_PIX;
        res_o.x_addr      = XY_W'(column_q);
        res_o.y_addr      = XY_W'(row_q);
        res_o.pixel_value = {cmd_i.data, pix_lo_q};
        // Wrap to the next row at the frame width.
        if ((WW + 1)'(column_q) + 1'b1 >= (WW + 1)'(width_eff)) begin
          column_d = '0;
          row_d    = row_q + 1'b1;
        end else begin
          column_d = column_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q   <= '0;
      start_q  <= '0;
      pix_lo_q <= '0;
      column_q <= '0;
      row_q    <= '0;
    end else begin
      word_q   <= word_d;
      start_q  <= start_d;
      pix_lo_q <= pix_lo_d;
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/event_packet_stream_parser.sv
// Flow: a byte accepted at one edge is classified and queued at that same
// edge; the back takes it when the result queue has room and queues any result it yields.
// Throughput: one byte per cycle; the front stalls (full high) only when the
// command queue fills, which happens only while the result queue is not drained.
// Reset: asynchronous, active low; parser expects a packet header, queues empty,
// frame_width reads 240 and frame_height 180.
`timescale 1ns / 1ps
`default_nettype none

module event_packet_stream_parser
  import epsp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Byte stream in
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte_i,
  // Results out
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             kind_o,
  output logic [XY_W-1:0]        x_addr_o,
  output logic [XY_W-1:0]        y_addr_o,
  output logic                   polarity_o,
  output logic [TS_W-1:0]        timestamp_o,
  output logic [TS_W-1:0]        end_timestamp_o,
  output logic [PIX_W-1:0]       pixel_value_o,
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic             cfg_wr;

  logic             in_accept;
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  epsp_cmd_t        cmd_wr, cmd_rd;
  logic             res_valid, res_full;
  epsp_res_t        res_wr, res_rd;

  // Configuration registers: one transfer per access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(240);
      frame_height_q <= CFG_W'(180);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
        default:          frame_width_q  <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Front: header tracking and byte classification. Every accepted byte
  // advances the packet counters; only bytes that matter reach the queue.
  assign full      = cmd_full;
  assign in_accept = push && !full;

  epsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr)
  );

  // Short command queue decouples the byte stream from result delivery.
  epsp_fifo #(
    .WIDTH ($bits(epsp_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_wr),
    .full_o    (cmd_full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (cmd_empty)
  );

  // Back: word assembly, frame raster tracking and result formation.
  epsp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!cmd_empty),
    .cmd_i          (cmd_rd),
    .cmd_pop_o      (cmd_pop),
    .res_full_i     (res_full),
    .res_valid_o    (res_valid),
    .res_o          (res_wr),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q)
  );

  // Result queue: hold finished results while the consumer stalls.
  epsp_fifo #(
    .WIDTH ($bits(epsp_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res_wr),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_rd),
    .empty_o   (empty)
  );

  assign kind_o          = res_rd.kind;
  assign x_addr_o        = res_rd.x_addr;
  assign y_addr_o        = res_rd.y_addr;
  assign polarity_o      = res_rd.polarity;
  assign timestamp_o     = res_rd.timestamp;
  assign end_timestamp_o = res_rd.end_timestamp;
  assign pixel_value_o   = res_rd.pixel_value;

  // Only the three defined result kinds ever leave the block.
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_POL || kind_o == KIND_PIX || kind_o == KIND_TS))
    else $error("undefined result kind");

  // Pixels never land past the maximum frame height.
  a_pix_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_PIX) |-> (32'(y_addr_o) < 32'(MAX_HEIGHT)))
    else $error("pixel row out of range");

  // Fields a kind does not use stay zero; this checks the polarity field.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_POL) |-> (polarity_o == 1'b0))
    else $error("polarity set on non-polarity result");

  // The back never drains a command while the result queue is full.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full |-> !cmd_pop)
    else $error("command drained into full result queue");

endmodule

`default_nettype wire

FILE: tb/tb_event_packet_stream_parser.sv
`timescale 1ns / 1ps

module tb_event_packet_stream_parser;
  import epsp_pkg::*;

  localparam int unsigned DIM_MAX = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 700;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED = 30;
  localparam int RANDOM_BYTES = 400;
  localparam int EVT_POL_BYTES = 8;

  localparam logic [2:0] ADDR_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_FRAME_HEIGHT = 3'd4;

  // Packet types the parser does not know.
  localparam logic [15:0] TYPE_NONE = 16'h0000;
  localparam logic [15:0] TYPE_MAX = 16'hFFFF;

  typedef enum int {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [7:0]        data_byte;
  logic              empty;
  logic              pop;
  logic [1:0]        res_kind;
  logic [XY_W-1:0]   res_x;
  logic [XY_W-1:0]   res_y;
  logic              res_polarity;
  logic [TS_W-1:0]   res_timestamp;
  logic [TS_W-1:0]   res_end_timestamp;
  logic [PIX_W-1:0]  res_pixel;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  event_packet_stream_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (res_kind),
    .x_addr_o        (res_x),
    .y_addr_o        (res_y),
    .polarity_o      (res_polarity),
    .timestamp_o     (res_timestamp),
    .end_timestamp_o (res_end_timestamp),
    .pixel_value_o   (res_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Parser image kept by the testbench, updated at every accepted byte.
  logic        hdr_phase;
  int unsigned hdr_idx;
  logic [15:0] pkt_type;
  logic [31:0] evt_bytes;
  logic [31:0] evt_total;
  logic [31:0] evt_pos;
  logic [31:0] evt_num;
  logic [31:0] evt_word;
  logic [31:0] evt_time;
  logic [7:0]  pix_lo;
  int unsigned pix_col;
  int unsigned pix_row;
  logic [10:0] cfg_width;
  logic [10:0] cfg_height;

  // Results still owed by the block, oldest first.
  epsp_res_t pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  int  burst_left = 0;
  bit  fast_mode = 1'b0;
  bit  hold_req = 1'b0;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", what, got, want));
    end
  endtask

  // Drop a byte into a little-endian word; byte zero starts the word afresh.
  function automatic logic [31:0] le_insert(input logic [31:0] word,
                                            input int unsigned idx,
                                            input logic [7:0] b);
    logic [31:0] r;
    if (idx == 0) return {24'd0, b};
    r = word;
    r[idx*8 +: 8] = b;
    return r;
  endfunction

  // Zero acts as one, anything past the maximum as the maximum.
  function automatic int unsigned eff_dim(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic void clear_parser_image();
    hdr_phase = 1'b1;
    hdr_idx = 0;
    pkt_type = '0;
    evt_bytes = '0;
    evt_total = '0;
    evt_pos = '0;
    evt_num = '0;
    evt_word = '0;
    evt_time = '0;
    pix_lo = '0;
    pix_col = 0;
    pix_row = 0;
    cfg_width = 11'd240;
    cfg_height = 11'd180;
  endfunction

  // Advance the parser image by one byte and queue the result it yields.
  function automatic void parse_byte(input logic [7:0] b);
    epsp_res_t   res;
    logic        emit;
    logic [31:0] pos;
    logic [31:0] tmp;
    int unsigned w_eff;
    int unsigned h_eff;
    res = '0;
    emit = 1'b0;

    if (hdr_phase) begin
      if (hdr_idx < 2) begin
        tmp = le_insert({16'd0, pkt_type}, hdr_idx, b);
        pkt_type = tmp[15:0];
      end else if (hdr_idx >= 4 && hdr_idx < 8) begin
        evt_bytes = le_insert(evt_bytes, hdr_idx - 4, b);
      end else if (hdr_idx >= 16 && hdr_idx < 20) begin
        evt_total = le_insert(evt_total, hdr_idx - 16, b);
      end
      if (hdr_idx + 1 >= HDR_BYTES) begin
        hdr_idx = 0;
        evt_pos = '0;
        evt_num = '0;
        // An empty packet goes straight on to the next header.
        hdr_phase = (evt_bytes == 0 || evt_total == 0);
      end else begin
        hdr_idx++;
      end
      return;
    end

    pos = evt_pos;
    if (pkt_type == TYPE_POL) begin
      if (pos < 4) evt_word = le_insert(evt_word, pos, b);
      else if (pos < 8) evt_time = le_insert(evt_time, pos - 4, b);
      // A short event never reaches its last timestamp byte.
      if (pos == POL_LAST) begin
        emit = 1'b1;
        res.kind = KIND_POL;
        res.x_addr = evt_word[31:17];
        res.y_addr = evt_word[16:2];
        res.polarity = evt_word[1];
        res.timestamp = evt_time;
      end
    end else if (pkt_type == TYPE_FRM) begin
      // Restart the raster at the first byte of every frame.
      if (pos == 0) begin
        pix_col = 0;
        pix_row = 0;
      end
      if (pos >= 4 && pos < 8) evt_time = le_insert(evt_time, pos - 4, b);
      else if (pos >= 8 && pos < 12) evt_word = le_insert(evt_word, pos - 8, b);
      if (pos == FRM_TS_LAST) begin
        emit = 1'b1;
        res.kind = KIND_TS;
        res.timestamp = evt_time;
        res.end_timestamp = evt_word;
      end else if (pos >= PIX_OFFSET) begin
        if (((pos - PIX_OFFSET) & 1) == 0) begin
          pix_lo = b;
        end else begin
          w_eff = eff_dim(cfg_width);
          h_eff = eff_dim(cfg_height);
          // Rows past the frame height are dropped and stop counting.
          if (pix_row < h_eff) begin
            emit = 1'b1;
            res.kind = KIND_PIX;
            res.x_addr = pix_col[XY_W-1:0];
            res.y_addr = pix_row[XY_W-1:0];
            res.pixel_value = {b, pix_lo};
            if (pix_col + 1 >= w_eff) begin
              pix_col = 0;
              pix_row++;
            end else begin
              pix_col++;
            end
          end
        end
      end
    end

    if (pos + 1 >= evt_bytes) begin
      evt_pos = '0;
      evt_num++;
      if (evt_num >= evt_total) begin
        evt_num = '0;
        hdr_phase = 1'b1;
        hdr_idx = 0;
      end
    end else begin
      evt_pos = pos + 1;
    end

    if (emit) pending_results.insert(pending_results.size(), res);
  endfunction

  // Offer one byte until the block takes it. Bursts of random length with
  // random gaps between them; fast_mode keeps the stream dense.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if (fast_mode) begin
        gap = 0;
        burst_left = 64;
      end else begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(1, 30);
      end
      if (gap > 0) begin
        push <= 1'b0;
        data_byte <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    data_byte <= b;
    // Hold the byte until a transfer happens.
    do @(posedge clk_i); while (full);
    parse_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] fill_value(input fill_e fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Header with random reserved bytes, then count events of size bytes each.
  task automatic send_packet(input logic [15:0] ptype, input logic [31:0] size,
                             input logic [31:0] count, input fill_e fill);
    logic [7:0] hdr [HDR_BYTES];
    for (int i = 0; i < HDR_BYTES; i++) hdr[i] = 8'($urandom);
    hdr[0] = ptype[7:0];
    hdr[1] = ptype[15:8];
    for (int i = 0; i < 4; i++) begin
      hdr[4 + i] = size[i*8 +: 8];
      hdr[16 + i] = count[i*8 +: 8];
    end
    for (int i = 0; i < HDR_BYTES; i++) send_byte(hdr[i]);
    if (size != 0 && count != 0) begin
      for (int unsigned e = 0; e < count; e++) begin
        for (int unsigned p = 0; p < size; p++) send_byte(fill_value(fill));
      end
    end
  endtask

  // Stop offering and let everything owed drain out of the block.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access phase for the write, then the same for a read back.
  task automatic write_reg(input logic [2:0] addr, input logic [10:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {21'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_FRAME_WIDTH) cfg_width = value;
    else cfg_height = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field($sformatf("register at 0x%0h", addr), prdata, {21'd0, value});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame_size(input logic [10:0] w, input logic [10:0] h);
    wait_idle();
    write_reg(ADDR_FRAME_WIDTH, w);
    write_reg(ADDR_FRAME_HEIGHT, h);
  endtask

  // Mostly small frames so that wrapping and dropping happen often.
  function automatic logic [10:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'($urandom_range(DIM_MAX + 1, 2047));
      2:       return 11'(DIM_MAX);
      default: return 11'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_polarity_events();
    send_packet(TYPE_POL, EVT_POL_BYTES, 2, FILL_ZERO);
    send_packet(TYPE_POL, EVT_POL_BYTES, 2, FILL_ONES);
    send_packet(TYPE_POL, EVT_POL_BYTES, 3, FILL_RAND);
    // Padding after the timestamp is skipped.
    send_packet(TYPE_POL, 13, 2, FILL_RAND);
    // Short events give nothing.
    send_packet(TYPE_POL, 7, 2, FILL_RAND);
    send_packet(TYPE_POL, 1, 3, FILL_RAND);
  endtask

  task automatic test_frame_events();
    set_frame_size(11'd3, 11'd2);
    // Eight pixels in a 3x2 frame: wrap twice, drop the last two; the
    // second frame restarts the raster.
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 8, 2, FILL_RAND);
    // Odd trailing byte after two pixels.
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 2 + 1, 1, FILL_ONES);
    // Too short for timestamps.
    send_packet(TYPE_FRM, 10, 2, FILL_RAND);
    send_packet(TYPE_FRM, FRM_TS_LAST + 1, 1, FILL_ZERO);
    send_packet(TYPE_FRM, PIX_OFFSET + 1, 1, FILL_RAND);
  endtask

  task automatic test_empty_and_unknown_packets();
    // Empty packets: the other count may be anything at all.
    send_packet(TYPE_POL, 0, $urandom, FILL_RAND);
    send_packet(TYPE_FRM, $urandom, 0, FILL_RAND);
    send_packet(TYPE_NONE, 5, 3, FILL_RAND);
    send_packet(TYPE_MAX, 9, 2, FILL_ONES);
    // Back in step afterwards.
    send_packet(TYPE_POL, EVT_POL_BYTES, 1, FILL_RAND);
  endtask

  task automatic test_size_extremes();
    set_frame_size(11'd0, 11'd0);
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 3, 2, FILL_RAND);
    // Width past the maximum: a short row never wraps.
    set_frame_size(11'h7FF, 11'd1);
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 10, 1, FILL_RAND);
    // Height past the maximum: one pixel per row, every row kept.
    set_frame_size(11'd1, 11'h7FF);
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 10, 1, FILL_RAND);
    set_frame_size(11'(DIM_MAX), 11'd1);
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 10, 1, FILL_RAND);
  endtask

  // Hold the result side off for a long stretch while a dense frame keeps
  // coming, so that both queues fill and full rises.
  task automatic test_backpressure();
    set_frame_size(11'(DIM_MAX), 11'(DIM_MAX));
    hold_req = 1'b1;
    fast_mode = 1'b1;
    burst_left = 0;
    send_packet(TYPE_FRM, PIX_OFFSET + 2 * 120, 1, FILL_RAND);
    fast_mode = 1'b0;
    burst_left = 0;
  endtask

  task automatic send_random_packet();
    int unsigned pick;
    fill_e       fill;
    logic [31:0] size;
    case ($urandom_range(0, 15))
      0:       fill = FILL_ZERO;
      1:       fill = FILL_ONES;
      default: fill = FILL_RAND;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      size = ($urandom_range(0, 3) != 0) ? EVT_POL_BYTES : $urandom_range(1, 16);
      send_packet(TYPE_POL, size, $urandom_range(1, 6), fill);
    end else if (pick < 7) begin
      if ($urandom_range(0, 3) != 0) begin
        size = PIX_OFFSET + 2 * $urandom_range(0, 20) + $urandom_range(0, 1);
      end else begin
        size = $urandom_range(1, 40);
      end
      send_packet(TYPE_FRM, size, $urandom_range(1, 3), fill);
    end else if (pick == 7) begin
      send_packet(16'($urandom_range(TYPE_FRM + 1, TYPE_MAX)), $urandom_range(1, 12),
                  $urandom_range(1, 4), fill);
    end else if (pick == 8) begin
      if ($urandom_range(0, 1) == 0) send_packet(16'($urandom), 0, $urandom, fill);
      else send_packet(16'($urandom), $urandom, 0, fill);
    end else begin
      // Noise: any type, odd sizes.
      send_packet(16'($urandom), $urandom_range(1, 48), $urandom_range(1, 3), fill);
    end
  endtask

  task automatic test_random_stream();
    int phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      set_frame_size(pick_dim(), pick_dim());
      phase_end = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < phase_end) send_random_packet();
    end
  endtask

  // Result side: runs of pops with stalls between them, plus the long
  // hold-off that test_backpressure asks for.
  initial begin : result_drain
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (run_left == 0 && stall_left == 0) begin
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        run_left--;
      end
    end
  end

  // Compare every result transfer with the oldest pending expectation.
  always @(posedge clk_i) begin : check_result
    epsp_res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result of kind %0d with nothing pending", res_kind));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", res_kind, want.kind);
        check_field("x_addr", res_x, want.x_addr);
        check_field("y_addr", res_y, want.y_addr);
        check_field("polarity", res_polarity, want.polarity);
        check_field("timestamp", res_timestamp, want.timestamp);
        check_field("end_timestamp", res_end_timestamp, want.end_timestamp);
        check_field("pixel_value", res_pixel, want.pixel_value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main
    rst_ni = 1'b0;
    push = 1'b0;
    data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clear_parser_image();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_polarity_events();
    test_frame_events();
    test_empty_and_unknown_packets();
    test_size_extremes();
    test_backpressure();
    test_random_stream();

    // Drain, then give stray results time to show up.
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/epsp_pkg.sv
hdl/epsp_fifo.sv
hdl/epsp_front.sv
hdl/epsp_back.sv
hdl/event_packet_stream_parser.sv
tb/tb_event_packet_stream_parser.sv
